/* src/ring_cellular_automaton_core_assert.svh */
// Assertion macros used by the ring cellular automaton sequencer.
`ifndef RING_CELLULAR_AUTOMATON_CORE_ASSERT_SVH
`define RING_CELLULAR_AUTOMATON_CORE_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define RCA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rca assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define RCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rca assertion failed");

`endif

/* src/rca_pkg.sv */
// Shared types and constants for the ring cellular automaton.
package rca_pkg;

   localparam int ROW_W      = 64;  // row port width
   localparam int RULE_W     = 32;  // rule table width
   localparam int RULE_IDX_W = 5;   // bits that select a rule table entry
   localparam int RAD_W      = 2;
   localparam int CNT_W      = 7;   // cell count and generation count width
   localparam int GEN_W      = 6;   // generation index width
   localparam int CSR_IDX_W  = 2;
   localparam int MAX_GENS   = 64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RULE_TABLE  = 2'd0,
      CSR_RADIUS      = 2'd1,
      CSR_CELL_COUNT  = 2'd2,
      CSR_GENERATIONS = 2'd3
   } csr_idx_type;

   // Configuration after range limiting.
   typedef struct packed {
      logic [RULE_W-1:0] rule;
      logic [RAD_W-1:0]  radius;
      logic [CNT_W-1:0]  cells;
      logic [CNT_W-1:0]  gens;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic step;
   } dp_cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

endpackage

/* src/rca_csr.sv */
// Configuration registers with range limiting of their values.
module rca_csr #(
   parameter int MAX_CELLS  = 64,
   parameter int MAX_RADIUS = 2
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  rca_pkg::csr_idx_type             csr_index,
   input  logic [rca_pkg::RULE_W-1:0]       csr_wdata,
   output rca_pkg::cfg_type                 cfg
);
   import rca_pkg::*;

   logic [RULE_W-1:0] rule_ff, rule_in;
   logic [RAD_W-1:0]  radius_ff, radius_in;
   logic [CNT_W-1:0]  cells_ff, cells_in;
   logic [CNT_W-1:0]  gens_ff, gens_in;

   always_comb begin
      rule_in   = rule_ff;
      radius_in = radius_ff;
      cells_in  = cells_ff;
      gens_in   = gens_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_RULE_TABLE:  rule_in   = csr_wdata;
            CSR_RADIUS:      radius_in = csr_wdata[RAD_W-1:0];
            CSR_CELL_COUNT:  cells_in  = csr_wdata[CNT_W-1:0];
            CSR_GENERATIONS: gens_in   = csr_wdata[CNT_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_ff   <= RULE_W'(110);
         radius_ff <= RAD_W'(1);
         cells_ff  <= CNT_W'(64);
         gens_ff   <= CNT_W'(1);
      end else begin
         rule_ff   <= rule_in;
         radius_ff <= radius_in;
         cells_ff  <= cells_in;
         gens_ff   <= gens_in;
      end
   end

   always_comb begin
      cfg.rule = rule_ff;
      if (radius_ff > RAD_W'(MAX_RADIUS)) begin
         cfg.radius = RAD_W'(MAX_RADIUS);
      end else begin
         cfg.radius = radius_ff;
      end
      // an empty ring behaves as a single cell
      if (cells_ff == '0) begin
         cfg.cells = CNT_W'(1);
      end else if (cells_ff > CNT_W'(MAX_CELLS)) begin
         cfg.cells = CNT_W'(MAX_CELLS);
      end else begin
         cfg.cells = cells_ff;
      end
      if (gens_ff > CNT_W'(MAX_GENS)) begin
         cfg.gens = CNT_W'(MAX_GENS);
      end else begin
         cfg.gens = gens_ff;
      end
   end

endmodule

/* src/rca_ctrl.sv */
// Sequencer: runs the generation loop and produces the result strobe and tags.
module rca_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rca_pkg::CNT_W-1:0]   gens,
   output logic                        busy,
   output rca_pkg::dp_cmd_type         cmd,
   output logic                        rsp_valid,
   output logic [rca_pkg::GEN_W-1:0]   rsp_generation_index,
   output logic                        rsp_last
);
   import rca_pkg::*;

   `include "ring_cellular_automaton_core_assert.svh"

   state_type        state_ff, state_in;
   logic [GEN_W-1:0] gen_ff, gen_in;
   logic [GEN_W-1:0] last_idx_ff, last_idx_in;
   logic             valid_ff, valid_in;
   logic [GEN_W-1:0] index_ff, index_in;
   logic             last_ff, last_in;
   logic             take;
   logic             at_last;

   assign take    = start && (state_ff == ST_IDLE);
   assign at_last = (gen_ff == last_idx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         gen_ff   <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         gen_ff   <= gen_in;
      end
   end

   always_ff @(posedge clock) begin
      last_idx_ff <= last_idx_in;
      index_ff    <= index_in;
      last_ff     <= last_in;
   end

   always_comb begin
      state_in    = state_ff;
      gen_in      = gen_ff;
      last_idx_in = last_idx_ff;
      valid_in    = 1'b0;
      index_in    = index_ff;
      last_in     = last_ff;
      cmd.load    = 1'b0;
      cmd.step    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               cmd.load = 1'b1;
               gen_in   = '0;
               // zero generations: row is loaded, nothing is emitted
               if (gens != '0) begin
                  last_idx_in = GEN_W'(gens - CNT_W'(1));
                  state_in    = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            valid_in = 1'b1;
            index_in = gen_ff;
            last_in  = at_last;
            gen_in   = gen_ff + GEN_W'(1);
            if (at_last) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   assign busy                 = (state_ff == ST_RUN);
   assign rsp_valid            = valid_ff;
   assign rsp_generation_index = index_ff;
   assign rsp_last             = last_ff;

   `RCA_ASSERT_NEXT(a_run_emits, clock, reset, state_ff == ST_RUN, valid_ff)
   `RCA_ASSERT_IMPL(a_last_frees, clock, reset, valid_ff && last_ff, state_ff == ST_IDLE)
   `RCA_ASSERT_NEXT(a_index_counts, clock, reset, valid_ff && !last_ff,
                    valid_ff && index_ff == GEN_W'($past(index_ff) + GEN_W'(1)))
   `RCA_ASSERT_NEXT(a_start_runs, clock, reset, take && gens != '0,
                    state_ff == ST_RUN && !valid_ff)

endmodule

/* src/rca_datapath.sv */
// Row register and the combinational next-generation network for the whole ring.
module rca_datapath #(
   parameter int MAX_CELLS  = 64,
   parameter int MAX_RADIUS = 2
) (
   input  logic                        clock,
   input  rca_pkg::dp_cmd_type         cmd,
   input  rca_pkg::cfg_type            cfg,
   input  logic [rca_pkg::ROW_W-1:0]   initial_row,
   output logic [MAX_CELLS-1:0]        row
);
   import rca_pkg::*;

   localparam int CELL_IDX_W = $clog2(MAX_CELLS);
   localparam int NB_W       = 2 * MAX_RADIUS + 1;

   logic [MAX_CELLS-1:0]  row_ff, row_in;
   logic [MAX_CELLS-1:0]  cell_mask;
   logic [MAX_CELLS-1:0]  nxt;
   logic [CELL_IDX_W-1:0] tail1_idx, tail2_idx;
   logic                  tail1, tail2, head1;

   // wrap sources: cells n-1 and n-2 (mod n) on the left, cell 1 (mod n) on the right
   assign tail1_idx = CELL_IDX_W'(cfg.cells - CNT_W'(1));
   assign tail2_idx = (cfg.cells >= CNT_W'(2)) ? CELL_IDX_W'(cfg.cells - CNT_W'(2)) : '0;
   assign tail1     = row_ff[tail1_idx];
   assign tail2     = row_ff[tail2_idx];
   assign head1     = (cfg.cells == CNT_W'(1)) ? row_ff[0] : row_ff[1];

   for (genvar gi = 0; gi < MAX_CELLS; gi++) begin : g_cell
      logic [NB_W-1:0]       nb;
      logic [RULE_IDX_W-1:0] pat;

      assign cell_mask[gi] = (cfg.cells > CNT_W'(gi));

      for (genvar gj = 0; gj < NB_W; gj++) begin : g_tap
         localparam int Pos = gi + gj - MAX_RADIUS;
         if (Pos == -1) begin : g_l1
            assign nb[gj] = tail1;
         end else if (Pos < -1) begin : g_l2
            assign nb[gj] = tail2;
         end else if (Pos <= gi) begin : g_in
            assign nb[gj] = row_ff[Pos];
         end else if (Pos < MAX_CELLS) begin : g_r
            assign nb[gj] = (cfg.cells > CNT_W'(Pos)) ? row_ff[Pos] :
                            ((cfg.cells == CNT_W'(Pos)) ? row_ff[0] : head1);
         end else begin : g_rw
            assign nb[gj] = (cfg.cells == CNT_W'(Pos)) ? row_ff[0] : head1;
         end
      end

      // leftmost neighbor lands in the most significant bit
      always_comb begin
         pat = '0;
         for (int j = 0; j < NB_W; j++) begin
            if (j >= MAX_RADIUS - int'(cfg.radius) && j <= MAX_RADIUS + int'(cfg.radius)) begin
               pat = {pat[RULE_IDX_W-2:0], nb[j]};
            end
         end
      end

      assign nxt[gi] = cfg.rule[pat] & cell_mask[gi];
   end

   always_comb begin
      row_in = row_ff;
      priority if (cmd.load) begin
         row_in = initial_row[MAX_CELLS-1:0] & cell_mask;
      end else if (cmd.step) begin
         row_in = nxt;
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
   end

   assign row = row_ff;

endmodule

/* src/ring_cellular_automaton_core.sv */
// Each generation of a row is computed into the row register, registered together with its
// valid strobe, index and last flag, and is taken at the edge that ends its strobe cycle.
// Throughput: one initial row at a time, for g generations (1..64) each; one whole
// generation per cycle from the all-cell next-row network, busy while it runs.
// A new start is taken in the cycle that shows the last result; zero generations load the row and emit nothing.
// Reset (synchronous) returns to idle and restores rule 110, radius 1, 64 cells,
// 1 generation. Results cannot be stalled by the receiver.
module ring_cellular_automaton_core #(
   parameter int MAX_CELLS  = 64,
   parameter int MAX_RADIUS = 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [rca_pkg::ROW_W-1:0]      req_initial_row,
   output logic                           rsp_valid,
   output logic [rca_pkg::ROW_W-1:0]      rsp_row,
   output logic [rca_pkg::GEN_W-1:0]      rsp_generation_index,
   output logic                           rsp_last,
   input  logic                           csr_we,
   input  rca_pkg::csr_idx_type           csr_index,
   input  logic [rca_pkg::RULE_W-1:0]     csr_wdata
);
   import rca_pkg::*;

   cfg_type              cfg;
   dp_cmd_type           cmd;
   logic [MAX_CELLS-1:0] dp_row;

   rca_csr #(
      .MAX_CELLS  (MAX_CELLS),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rca_ctrl u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .gens                 (cfg.gens),
      .busy                 (busy),
      .cmd                  (cmd),
      .rsp_valid            (rsp_valid),
      .rsp_generation_index (rsp_generation_index),
      .rsp_last             (rsp_last)
   );

   rca_datapath #(
      .MAX_CELLS  (MAX_CELLS),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_datapath (
      .clock       (clock),
      .cmd         (cmd),
      .cfg         (cfg),
      .initial_row (req_initial_row),
      .row         (dp_row)
   );

   assign rsp_row = ROW_W'(dp_row);

endmodule

/* dv/ring_cellular_automaton_core_test.sv */
// Self-checking testbench for the ring cellular automaton core.
module ring_cellular_automaton_core_test;
   import rca_pkg::*;

   localparam int QUIET_LIMIT = 5000;  // cycles with no transfer before giving up
   localparam int N_PLAN      = 21;
   localparam int N_PHASES    = 8;
   localparam int PHASE_ROWS  = 50;

   typedef struct {
      bit [ROW_W-1:0] row;
      bit [GEN_W-1:0] index;
      bit             last;
   } generation_type;

   typedef struct packed {
      bit [31:0] rule;
      bit [31:0] radius;
      bit [31:0] cells;
      bit [31:0] gens;
   } settings_type;

   typedef struct {
      settings_type   cfg;
      bit [ROW_W-1:0] init;
      bit             known;
      bit [ROW_W-1:0] gen0;
   } plan_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [ROW_W-1:0]    req_initial_row;
   logic                rsp_valid;
   logic [ROW_W-1:0]    rsp_row;
   logic [GEN_W-1:0]    rsp_generation_index;
   logic                rsp_last;
   logic                csr_we;
   csr_idx_type         csr_index;
   logic [RULE_W-1:0]   csr_wdata;

   ring_cellular_automaton_core dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_initial_row      (req_initial_row),
      .rsp_valid            (rsp_valid),
      .rsp_row              (rsp_row),
      .rsp_generation_index (rsp_generation_index),
      .rsp_last             (rsp_last),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   // shadow registers as the block holds them
   bit [31:0]      rule_sh;
   bit [1:0]       radius_sh;
   bit [6:0]       cells_sh;
   bit [6:0]       gens_sh;
   settings_type   applied;

   generation_type pending_gens[$];
   int             mismatches;
   int             rows_sent;
   int             gens_checked;
   int             settings_used;
   int             quiet;

   plan_type plan [N_PLAN] = '{
      // reset settings
      '{'{32'd110, 32'd1, 32'd64, 32'd1}, 64'h0, 1'b1, 64'h0},
      '{'{32'd110, 32'd1, 32'd64, 32'd1}, '1, 1'b1, 64'h0},
      '{'{32'd110, 32'd1, 32'd64, 32'd1}, 64'h1, 1'b1, 64'h8000_0000_0000_0001},
      // shift toward cell 0, wraps at the ends
      '{'{32'd170, 32'd1, 32'd64, 32'd3}, 64'h1, 1'b1, 64'h8000_0000_0000_0000},
      // identity rule
      '{'{32'd204, 32'd1, 32'd64, 32'd4}, 64'hDEAD_BEEF_0123_4567, 1'b1,
        64'hDEAD_BEEF_0123_4567},
      '{'{32'hFFFF_FFFF, 32'd2, 32'd64, 32'd2}, 64'h0, 1'b1, '1},
      '{'{32'd0, 32'd2, 32'd64, 32'd1}, '1, 1'b1, 64'h0},
      // radius zero: invert, upper row bits beyond the ring dropped
      '{'{32'd1, 32'd0, 32'd8, 32'd2}, 64'hFFFF_FFFF_FFFF_FFA5, 1'b1, 64'h5A},
      // junk above the radius field
      '{'{32'd2, 32'hFFFF_FFFC, 32'd8, 32'd1}, 64'hA5, 1'b1, 64'hA5},
      // radius above the maximum
      '{'{32'd30, 32'd3, 32'd64, 32'd5}, 64'h0123_4567_89AB_CDEF, 1'b0, 64'h0},
      // zero cells act as one cell
      '{'{32'd30, 32'd1, 32'd0, 32'd3}, '1, 1'b1, 64'h0},
      '{'{32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1}, 64'h0, 1'b1, 64'h1},
      // neighborhood wider than the ring
      '{'{32'd110, 32'd2, 32'd3, 32'd6}, 64'h5, 1'b0, 64'h0},
      '{'{32'hA5A5_5A5A, 32'd2, 32'd2, 32'd3}, 64'h3, 1'b0, 64'h0},
      '{'{32'd90, 32'd1, 32'd127, 32'd2}, 64'hF0F0_1234_8765_0F0F, 1'b0, 64'h0},
      '{'{32'd110, 32'd1, 32'd65, 32'd1}, 64'h8000_0000_0000_0001, 1'b0, 64'h0},
      // zero generations: nothing comes back
      '{'{32'd184, 32'd1, 32'd64, 32'd0}, 64'hFFFF_0000_1234_5678, 1'b0, 64'h0},
      '{'{32'd184, 32'd1, 32'd64, 32'd64}, 64'h1, 1'b0, 64'h0},
      '{'{32'd184, 32'd1, 32'd64, 32'd127}, 64'hFFFF_0000_FFFF_0000, 1'b0, 64'h0},
      '{'{32'd110, 32'd1, 32'd64, 32'hFFFF_FF81}, 64'h0F0F_0F0F_F0F0_F0F0, 1'b0, 64'h0},
      '{'{32'h9669_6996, 32'd2, 32'd64, 32'd10}, 64'h7777_1111_2222_EEEE, 1'b0, 64'h0}
   };

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input bit [ROW_W-1:0] got,
                                  input bit [ROW_W-1:0] want);
      $display("mismatch: %s got %h want %h", what, got, want);
      mismatches++;
   endtask

   // one generation of the ring
   function automatic bit [ROW_W-1:0] evolve(input bit [ROW_W-1:0] cur, input int n,
                                              input int r, input bit [31:0] rule);
      bit [ROW_W-1:0] nxt;
      bit [4:0]       pat;
      int             pos;
      nxt = '0;
      for (int i = 0; i < n; i++) begin
         pat = '0;
         for (int k = 0; k <= 2 * r; k++) begin
            pos = (i + 3 * n + k - r) % n;
            pat = {pat[3:0], cur[pos]};
         end
         nxt[i] = rule[pat];
      end
      return nxt;
   endfunction

   task automatic queue_generations(input bit [ROW_W-1:0] init,
                                    output bit [ROW_W-1:0] first);
      int             n, r, g;
      bit [ROW_W-1:0] mask, cur;
      generation_type e;
      n = (cells_sh == 0) ? 1 : (cells_sh > 64) ? 64 : int'(cells_sh);
      r = (radius_sh > 2) ? 2 : int'(radius_sh);
      g = (gens_sh > MAX_GENS) ? MAX_GENS : int'(gens_sh);
      mask = (n == 64) ? '1 : ((64'd1 << n) - 64'd1);
      cur = init & mask;
      first = cur;
      for (int k = 0; k < g; k++) begin
         cur = evolve(cur, n, r, rule_sh) & mask;
         if (k == 0) first = cur;
         e.row = cur;
         e.index = k[GEN_W-1:0];
         e.last = (k + 1 == g);
         pending_gens = {pending_gens, e};
      end
   endtask

   // holds start until the block takes the row
   task automatic send_row(input bit [ROW_W-1:0] init, output bit [ROW_W-1:0] first);
      start <= 1'b1;
      req_initial_row <= init;
      do @(posedge clock); while (busy);
      queue_generations(init, first);
      rows_sent++;
   endtask

   task automatic idle_cycles(input int pct);
      while ($urandom_range(0, 99) < pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // wait out every pending generation, plus slack for a zero-generation row
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_gens.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input bit [31:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_RULE_TABLE:  rule_sh = data;
         CSR_RADIUS:      radius_sh = data[1:0];
         CSR_CELL_COUNT:  cells_sh = data[6:0];
         CSR_GENERATIONS: gens_sh = data[6:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input settings_type s);
      drain();
      write_reg(CSR_RULE_TABLE, s.rule);
      write_reg(CSR_RADIUS, s.radius);
      write_reg(CSR_CELL_COUNT, s.cells);
      write_reg(CSR_GENERATIONS, s.gens);
      csr_we <= 1'b0;
      @(posedge clock);
      applied = s;
      settings_used++;
   endtask

   function automatic settings_type pick_settings(input int phase);
      settings_type s;
      bit [31:0] junk;
      if (phase == 0) return '{$urandom, 32'd2, 32'd64, 32'd64};
      if (phase == 1) return '{$urandom, 32'd0, 32'd1, 32'd1};
      junk = ($urandom_range(0, 3) == 0) ? ($urandom & 32'hFFFF_FF80) : 32'h0;
      case ($urandom_range(0, 5))
         0: s.rule = 32'd30;
         1: s.rule = 32'd110;
         2: s.rule = 32'd184;
         default: s.rule = $urandom;
      endcase
      s.radius = junk | $urandom_range(0, 3);
      case ($urandom_range(0, 3))
         0: s.cells = junk | $urandom_range(0, 127);
         1: s.cells = 32'd64;
         default: s.cells = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 7))
         0: s.gens = 32'd0;
         1: s.gens = junk | $urandom_range(64, 127);
         default: s.gens = $urandom_range(1, 8);
      endcase
      return s;
   endfunction

   function automatic bit [ROW_W-1:0] random_row();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return 64'd1 << $urandom_range(0, 63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // results are taken on the edge that ends their strobe cycle
   always @(posedge clock) begin
      generation_type e;
      if (!reset && rsp_valid) begin
         if (pending_gens.size() == 0) begin
            report_mismatch("unexpected generation row", rsp_row, '0);
         end else begin
            e = pending_gens.pop_front();
            gens_checked++;
            if (rsp_row !== e.row) report_mismatch("row", rsp_row, e.row);
            if (rsp_generation_index !== e.index)
               report_mismatch("generation_index", ROW_W'(rsp_generation_index),
                               ROW_W'(e.index));
            if (rsp_last !== e.last)
               report_mismatch("last", ROW_W'(rsp_last), ROW_W'(e.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we)
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", quiet);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      bit [ROW_W-1:0] first;
      int             idle_pct [N_PHASES];
      idle_pct = '{0, 60, 20, 0, 60, 20, 0, 60};
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_initial_row = '0;
      csr_we = 1'b0;
      csr_index = CSR_RULE_TABLE;
      csr_wdata = '0;
      rule_sh = 32'd110;
      radius_sh = 2'd1;
      cells_sh = 7'd64;
      gens_sh = 7'd1;
      applied = '{32'd110, 32'd1, 32'd64, 32'd1};
      mismatches = 0;
      rows_sent = 0;
      gens_checked = 0;
      settings_used = 1;
      quiet = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_PLAN; i++) begin
         if (plan[i].cfg != applied) apply_settings(plan[i].cfg);
         send_row(plan[i].init, first);
         if (plan[i].known && first !== plan[i].gen0)
            report_mismatch("predicted generation 0", first, plan[i].gen0);
      end

      for (int p = 0; p < N_PHASES; p++) begin
         apply_settings(pick_settings(p));
         for (int i = 0; i < PHASE_ROWS; i++) begin
            idle_cycles(idle_pct[p]);
            send_row(random_row(), first);
            if ($urandom_range(0, 39) == 0) drain();
         end
      end

      drain();
      repeat (4) @(posedge clock);
      $display("%0d initial rows over %0d settings, %0d generation rows compared",
               rows_sent, settings_used, gens_checked);
      $display("covered rule, radius, ring size and generation extremes, with and without gaps");
      if (mismatches == 0 && pending_gens.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
